// File: hw/rtl/toer_pkg.sv
// Shared types and constants of the time-ordered event ring.
// Command, status and register codes; stream field positions.
// No dependencies.
package toer_pkg;

	localparam int DEPTH_DEF     = 32;
	localparam int TIME_BITS_DEF = 32;
	localparam int PAY_W         = 32;
	localparam int WORD_W        = 32;
	localparam int MAX_RES       = 31;

	localparam int IN_W  = 144;
	localparam int OUT_W = 72;

	// input beat field positions
	localparam int I_CMD_LO  = 0;
	localparam int I_TIME_LO = 3;
	localparam int I_MAG_LO  = 35;
	localparam int I_NOW_LO  = 67;
	localparam int I_WIN_LO  = 99;
	localparam int I_CAP_LO  = 131;
	localparam int I_BACK_LO = 137;

	// output beat field positions
	localparam int O_ST_LO   = 0;
	localparam int O_TIME_LO = 3;
	localparam int O_MAG_LO  = 35;

	localparam logic [2:0] CMD_INSERT = 3'd0;
	localparam logic [2:0] CMD_APPEND = 3'd1;
	localparam logic [2:0] CMD_PUT    = 3'd2;
	localparam logic [2:0] CMD_FIND   = 3'd3;
	localparam logic [2:0] CMD_PREV   = 3'd4;
	localparam logic [2:0] CMD_LIST   = 3'd5;
	localparam logic [2:0] CMD_REWIND = 3'd6;
	localparam logic [2:0] CMD_CLEAR  = 3'd7;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_ORDER  = 3'd1;
	localparam logic [2:0] ST_REJECT = 3'd2;
	localparam logic [2:0] ST_NFOUND = 3'd3;
	localparam logic [2:0] ST_RECENT = 3'd4;
	localparam logic [2:0] ST_BEFORE = 3'd5;

	localparam logic CFG_POLICY = 1'b0;
	localparam logic CFG_KEEP   = 1'b1;

	typedef struct packed {
		logic [2:0]        status;
		logic              item_valid;
		logic [WORD_W-1:0] out_time;
		logic [PAY_W-1:0]  out_magnitude;
		logic              last_item;
	} toer_res_t;

endpackage

// File: hw/rtl/toer_cell.sv
// One slot of the event ring: time and payload, loaded from the write bus
// or shifted in from the next lower slot. Depends on toer_pkg.
module toer_cell #(
	parameter int DEPTH     = toer_pkg::DEPTH_DEF,
	parameter int TIME_BITS = toer_pkg::TIME_BITS_DEF,
	parameter int IDX       = 0
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [$clog2(DEPTH)-1:0]     wpos,
	input  logic                         sh_en,
	input  logic [$clog2(DEPTH)-1:0]     sh_base,
	input  logic [$clog2(DEPTH)-1:0]     sh_len,
	input  logic [TIME_BITS-1:0]         wr_time,
	input  logic [toer_pkg::PAY_W-1:0]   wr_pay,
	input  logic [TIME_BITS-1:0]         nb_time,
	input  logic [toer_pkg::PAY_W-1:0]   nb_pay,
	output logic [TIME_BITS-1:0]         cell_time,
	output logic [toer_pkg::PAY_W-1:0]   cell_pay
);
	import toer_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam logic [PW:0] MY  = (PW+1)'(IDX);
	localparam logic [PW:0] DPT = (PW+1)'(DEPTH);

	logic [PW:0] rel_pos;
	logic        take_wr;
	logic        take_nb;
	logic [TIME_BITS-1:0] time_q;
	logic [PAY_W-1:0]     pay_q;

	// circular distance of this slot above the shift base
	assign rel_pos = (MY >= {1'b0, sh_base}) ? MY - {1'b0, sh_base}
	                                         : MY + DPT - {1'b0, sh_base};
	assign take_wr = we && (wpos == MY[PW-1:0]);
	assign take_nb = sh_en && (rel_pos != '0) && (rel_pos <= {1'b0, sh_len});

	always_ff @(posedge clk) begin
		if (take_wr) begin
			time_q <= wr_time;
			pay_q  <= wr_pay;
		end else if (take_nb) begin
			time_q <= nb_time;
			pay_q  <= nb_pay;
		end
	end

	assign cell_time = time_q;
	assign cell_pay  = pay_q;

endmodule

// File: hw/rtl/time_ordered_event_ring_unit.sv
// Time-ordered event ring: a chain of slot cells plus a walking sequencer.
// Append, put_now, rewind, clear: resolved in the execute state, with no walk.
// Insert, find, previous: may walk slot by slot (up to DEPTH) before the result beat.
// list_window: one result beat per listed event, or one item-less beat if none listed.
// One item in flight at a time; s_tready is high only while the sequencer is idle.
// Reset clears pointers, state, counters and config; slot contents start undefined.
module time_ordered_event_ring_unit #(
	parameter int DEPTH     = toer_pkg::DEPTH_DEF,
	parameter int TIME_BITS = toer_pkg::TIME_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// cmd, time stamp, event_magnitude, now_tick, window_length,
	// list_capacity, back_steps (lowest first), zero padded
	input  logic [toer_pkg::IN_W-1:0]     s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// status, out_time, out_magnitude (lowest first), zero padded
	output logic [toer_pkg::OUT_W-1:0]    m_tdata,
	// item_valid
	output logic                          m_tuser,
	output logic                          m_tlast,
	input  logic                          cfg_we,
	input  logic                          cfg_idx,
	input  logic [toer_pkg::WORD_W-1:0]   cfg_data
);
	import toer_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);
	localparam int CW = (TIME_BITS > WORD_W) ? TIME_BITS : WORD_W;
	localparam logic [NW-1:0] NDEPTH = NW'(DEPTH);
	localparam logic [PW-1:0] PLAST  = PW'(DEPTH - 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_WALK  = 3'd2;
	localparam logic [2:0] S_LWALK = 3'd3;
	localparam logic [2:0] S_LFIN  = 3'd4;

	function automatic logic [PW-1:0] p_inc(input logic [PW-1:0] p);
		return (p == PLAST) ? '0 : p + PW'(1);
	endfunction

	function automatic logic [PW-1:0] p_dec(input logic [PW-1:0] p);
		return (p == '0) ? PLAST : p - PW'(1);
	endfunction

	function automatic logic [PW-1:0] p_sub(input logic [PW-1:0] a, input logic [PW-1:0] b);
		logic [PW:0] s;
		s = (a >= b) ? {1'b0, a} - {1'b0, b} : {1'b0, a} + (PW+1)'(DEPTH) - {1'b0, b};
		return s[PW-1:0];
	endfunction

	function automatic logic [WORD_W-1:0] to_word(input logic [TIME_BITS-1:0] x);
		logic [CW-1:0] w;
		w = CW'(x);
		return w[WORD_W-1:0];
	endfunction

	// control and configuration
	logic [2:0]  state_q, state_d;
	logic [PW-1:0] head_q, head_d, tail_q, tail_d, rd_q, rd_d, p_q, p_d;
	logic [NW-1:0] n_q, n_d;
	logic [4:0]  cnt_q, cnt_d;
	logic [4:0]  bk_q, bk_d;
	logic        pend_v_q, pend_v_d;
	logic        pol_q;
	logic [WORD_W-1:0] keep_q;

	// latched item
	logic [2:0]           cmd_q;
	logic [TIME_BITS-1:0] t_q, lo_q, lo_d;
	logic [PAY_W-1:0]     m_q;
	logic [WORD_W-1:0]    now_q, dur_q;
	logic [5:0]           cap_q;
	logic [TIME_BITS-1:0] pend_t_q, pend_t_d;
	logic [PAY_W-1:0]     pend_m_q, pend_m_d;

	// cell chain
	logic [TIME_BITS-1:0] c_time [DEPTH];
	logic [PAY_W-1:0]     c_pay  [DEPTH];
	logic                 we, sh_en;
	logic [PW-1:0]        wpos, sh_base, sh_len;
	logic [TIME_BITS-1:0] wt;
	logic [PAY_W-1:0]     wm;

	// result register
	logic      ovalid_q;
	toer_res_t res_q, res_d;
	logic      emit, ofree;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			localparam int NB = (gi == 0) ? DEPTH - 1 : gi - 1;
			toer_cell #(.DEPTH(DEPTH), .TIME_BITS(TIME_BITS), .IDX(gi)) u_cell (
				.clk(clk), .we(we), .wpos(wpos), .sh_en(sh_en), .sh_base(sh_base),
				.sh_len(sh_len), .wr_time(wt), .wr_pay(wm), .nb_time(c_time[NB]),
				.nb_pay(c_pay[NB]), .cell_time(c_time[gi]), .cell_pay(c_pay[gi])
			);
		end
	endgenerate

	// grow-at-tail evaluation
	logic [PW-1:0]        g_nt, g_head;
	logic                 g_full, g_rej, g_recent;
	logic [2:0]           g_st;
	logic [CW-1:0]        now_c, old_c, keep_c;
	logic                 empty;
	logic [TIME_BITS-1:0] cur_t, rd_t, tail_t, tp;
	logic [PAY_W-1:0]     cur_m;
	logic [CW-1:0]        t_c, dur_c;

	assign empty  = (head_q == tail_q);
	assign g_nt   = p_inc(tail_q);
	assign g_full = (g_nt == head_q);
	assign g_rej  = g_full && pol_q;
	assign now_c  = CW'(now_q);
	assign old_c  = CW'(c_time[p_inc(head_q)]);
	assign keep_c = CW'(keep_q);
	assign g_recent = (now_c < old_c) || ((now_c - old_c) < keep_c);
	assign g_st   = g_rej ? ST_REJECT : ((g_full && g_recent) ? ST_RECENT : ST_OK);
	assign g_head = g_full ? p_inc(head_q) : head_q;
	assign cur_t  = c_time[p_q];
	assign cur_m  = c_pay[p_q];
	assign rd_t   = c_time[rd_q];
	assign tail_t = c_time[tail_q];
	assign tp     = TIME_BITS'(now_q);
	assign t_c    = CW'(t_q);
	assign dur_c  = CW'(dur_q);
	assign ofree  = !ovalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);

	logic [PW-1:0] off, ipn, distr;
	logic          lstop, hit;
	logic [CW-1:0] lo_c;

	assign off   = p_sub(tail_q, p_q);
	assign ipn   = p_sub(g_nt, off + PW'(1));
	assign distr = p_sub(g_nt, rd_q);
	assign lo_c  = (dur_c > t_c) ? '0 : t_c - dur_c;
	assign lstop = (n_q == NDEPTH) || (cur_t < lo_q) ||
	               ((6'(cnt_q) + 6'd1) >= cap_q) || (cnt_q == 5'(MAX_RES));
	assign hit   = (cur_t <= t_q);

	always_comb begin
		state_d = state_q;
		head_d = head_q; tail_d = tail_q; rd_d = rd_q;
		p_d = p_q; n_d = n_q; cnt_d = cnt_q; bk_d = bk_q; lo_d = lo_q;
		pend_v_d = pend_v_q; pend_t_d = pend_t_q; pend_m_d = pend_m_q;
		we = 1'b0; wpos = tail_q; wt = t_q; wm = m_q;
		sh_en = 1'b0; sh_base = ipn; sh_len = off + PW'(1);
		emit = 1'b0;
		res_d = '{status: ST_OK, item_valid: 1'b0, out_time: '0, out_magnitude: '0,
		          last_item: 1'b1};
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (ofree) begin
					state_d = S_IDLE;
					case (cmd_q)
						CMD_INSERT: begin
							if (empty) begin
								emit = 1'b1;
								res_d.status = g_st;
								if (!g_rej) begin
									head_d = g_head; tail_d = g_nt;
									we = 1'b1; wpos = g_nt;
								end
							end else begin
								p_d = p_inc(head_q); n_d = '0; state_d = S_WALK;
							end
						end
						CMD_APPEND: begin
							emit = 1'b1;
							if (!empty && t_q < tail_t) begin
								res_d.status = ST_ORDER;
							end else if (empty || t_q > tail_t) begin
								res_d.status = g_st;
								if (!g_rej) begin
									head_d = g_head; tail_d = g_nt;
									we = 1'b1; wpos = g_nt;
								end
							end else begin
								we = 1'b1; wpos = tail_q;
							end
						end
						CMD_PUT: begin
							emit = 1'b1;
							wt = tp;
							if (empty) begin
								res_d.status = g_st;
								if (!g_rej) begin
									head_d = g_head; tail_d = g_nt; rd_d = g_nt;
									we = 1'b1; wpos = g_nt;
								end
							end else if (rd_q == head_q || tp > rd_t) begin
								if (rd_q == tail_q) begin
									res_d.status = g_st;
									if (!g_rej) begin
										head_d = g_head; tail_d = g_nt; rd_d = g_nt;
										we = 1'b1; wpos = g_nt;
									end
								end else begin
									rd_d = p_inc(rd_q);
									we = 1'b1; wpos = p_inc(rd_q);
								end
							end else if (tp < rd_t) begin
								res_d.status = ST_ORDER;
							end else begin
								we = 1'b1; wpos = rd_q;
							end
						end
						CMD_FIND, CMD_PREV: begin
							p_d = rd_q; n_d = '0; state_d = S_WALK;
						end
						CMD_LIST: begin
							if (empty || rd_q == head_q) begin
								emit = 1'b1;
							end else begin
								p_d = rd_q; n_d = '0; cnt_d = '0; pend_v_d = 1'b0;
								lo_d = lo_c[TIME_BITS-1:0];
								state_d = S_LWALK;
							end
						end
						CMD_REWIND: begin
							emit = 1'b1; rd_d = head_q;
						end
						default: begin
							emit = 1'b1; head_d = '0; tail_d = '0; rd_d = '0;
						end
					endcase
				end
			end
			S_WALK: begin
				if (cmd_q == CMD_INSERT) begin
					if (n_q != NDEPTH && p_q != tail_q && t_q > cur_t) begin
						p_d = p_inc(p_q); n_d = n_q + NW'(1);
					end else if (ofree) begin
						emit = 1'b1; state_d = S_IDLE;
						if (t_q == cur_t) begin
							we = 1'b1; wpos = p_q;
						end else if (t_q > cur_t) begin
							res_d.status = g_st;
							if (!g_rej) begin
								head_d = g_head; tail_d = g_nt;
								we = 1'b1; wpos = g_nt;
							end
						end else begin
							res_d.status = g_st;
							if (!g_rej) begin
								head_d = g_head; tail_d = g_nt;
								if (off >= distr) begin
									rd_d = p_inc(rd_q);
									if (g_st == ST_OK) res_d.status = ST_BEFORE;
								end
								// shift the slots above the insert slot up and write the new event into it together
								sh_en = 1'b1;
								we = 1'b1; wpos = ipn;
							end
						end
					end
				end else begin
					if (n_q == NDEPTH || p_q == head_q) begin
						if (ofree) begin
							emit = 1'b1; state_d = S_IDLE;
							res_d.status = ST_NFOUND;
						end
					end else if ((cmd_q == CMD_FIND) ? (cur_t == t_q) : (bk_q == '0)) begin
						if (ofree) begin
							emit = 1'b1; state_d = S_IDLE;
							res_d.item_valid = 1'b1;
							res_d.out_time = to_word(cur_t);
							res_d.out_magnitude = cur_m;
						end
					end else begin
						if (cmd_q == CMD_PREV) bk_d = bk_q - 5'd1;
						p_d = p_dec(p_q); n_d = n_q + NW'(1);
					end
				end
			end
			S_LWALK: begin
				if (lstop) begin
					state_d = S_LFIN;
				end else if (!(hit && pend_v_q && !ofree)) begin
					if (hit) begin
						// release the held event once another hit is known to follow it in the list
						if (pend_v_q) begin
							emit = 1'b1;
							res_d.item_valid = 1'b1;
							res_d.out_time = to_word(pend_t_q);
							res_d.out_magnitude = pend_m_q;
							res_d.last_item = 1'b0;
						end
						pend_v_d = 1'b1; pend_t_d = cur_t; pend_m_d = cur_m;
						cnt_d = cnt_q + 5'd1;
					end
					p_d = p_dec(p_q); n_d = n_q + NW'(1);
					if (p_dec(p_q) == head_q) state_d = S_LFIN;
				end
			end
			S_LFIN: begin
				if (ofree) begin
					emit = 1'b1; state_d = S_IDLE; pend_v_d = 1'b0;
					if (pend_v_q) begin
						res_d.item_valid = 1'b1;
						res_d.out_time = to_word(pend_t_q);
						res_d.out_magnitude = pend_m_q;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			tail_q   <= '0;
			rd_q     <= '0;
			p_q      <= '0;
			n_q      <= '0;
			cnt_q    <= '0;
			bk_q     <= '0;
			pend_v_q <= 1'b0;
			ovalid_q <= 1'b0;
			pol_q    <= 1'b0;
			keep_q   <= '0;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			rd_q     <= rd_d;
			p_q      <= p_d;
			n_q      <= n_d;
			cnt_q    <= cnt_d;
			bk_q     <= (state_q == S_IDLE) ? s_tdata[I_BACK_LO +: 5] : bk_d;
			pend_v_q <= pend_v_d;
			if (emit) ovalid_q <= 1'b1;
			else if (m_tready) ovalid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_idx)
					CFG_POLICY: pol_q  <= cfg_data[0];
					default:    keep_q <= cfg_data;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q <= s_tdata[I_CMD_LO +: 3];
			t_q   <= TIME_BITS'(s_tdata[I_TIME_LO +: WORD_W]);
			m_q   <= s_tdata[I_MAG_LO +: PAY_W];
			now_q <= s_tdata[I_NOW_LO +: WORD_W];
			dur_q <= s_tdata[I_WIN_LO +: WORD_W];
			cap_q <= s_tdata[I_CAP_LO +: 6];
		end
		lo_q     <= lo_d;
		pend_t_q <= pend_t_d;
		pend_m_q <= pend_m_d;
		if (emit) res_q <= res_d;
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {{(OUT_W - 3 - WORD_W - PAY_W){1'b0}},
	                   res_q.out_magnitude, res_q.out_time, res_q.status};
	assign m_tuser  = res_q.item_valid;
	assign m_tlast  = res_q.last_item;

`ifndef SYNTHESIS
	a_pend_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> (state_q == S_LWALK || state_q == S_LFIN))
		else $error("held list event outside a list walk");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 5'(MAX_RES))
		else $error("list count beyond result limit");
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q <= PLAST) && (tail_q <= PLAST) && (rd_q <= PLAST))
		else $error("ring pointer out of range");
	a_busy_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_EXEC))
		else $error("accepted beat did not start execution");
`endif

endmodule

// File: bench/time_ordered_event_ring_unit_tb.sv
// Testbench of the time-ordered event ring unit: directed and random command streams.
// Predicts every result beat with an in-bench model of the ring and checks it field by field.
// Depends on toer_pkg and time_ordered_event_ring_unit.
module time_ordered_event_ring_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import toer_pkg::*;

	localparam int RING = 32;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic m_tuser;
	logic m_tlast;
	logic cfg_we = 1'b0;
	logic cfg_idx = 1'b0;
	logic [WORD_W-1:0] cfg_data = '0;

	time_ordered_event_ring_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// predicted ring contents and pointers
	logic [31:0] ring_time [RING];
	logic [31:0] ring_pay [RING];
	int unsigned ring_head, ring_tail, ring_rd;
	logic policy_reject;
	logic [31:0] keep_ticks;

	toer_res_t pending_results[$];
	int errors = 0;
	int items_sent = 0;
	int beats_checked = 0;
	int burst_left = 0;
	bit stall_on = 1'b1;

	function automatic int unsigned nxt(int unsigned p);
		return (p + 1) % RING;
	endfunction

	function automatic int unsigned prv(int unsigned p);
		return (p + RING - 1) % RING;
	endfunction

	function automatic logic [2:0] ring_grow(logic [31:0] now);
		int unsigned nt;
		logic [31:0] old;
		logic [2:0] st;
		nt = nxt(ring_tail);
		st = ST_OK;
		if (nt == ring_head) begin
			if (policy_reject)
				return ST_REJECT;
			old = ring_time[nxt(ring_head)];
			if (now < old || now - old < keep_ticks)
				st = ST_RECENT;
			ring_head = nxt(ring_head);
		end
		ring_tail = nt;
		return st;
	endfunction

	function automatic logic [2:0] ring_insert(logic [31:0] t, logic [31:0] m, logic [31:0] now);
		int unsigned ip, off, rd_span, to, n;
		logic [2:0] st;
		if (ring_head == ring_tail) begin
			st = ring_grow(now);
			if (st != ST_REJECT) begin
				ring_time[ring_tail] = t;
				ring_pay[ring_tail] = m;
			end
			return st;
		end
		ip = nxt(ring_head);
		for (n = 0; n < RING && ip != ring_tail && t > ring_time[ip]; n++)
			ip = nxt(ip);
		if (t == ring_time[ip]) begin
			ring_pay[ip] = m;
			return ST_OK;
		end
		if (t > ring_time[ip]) begin
			st = ring_grow(now);
			if (st != ST_REJECT) begin
				ring_time[ring_tail] = t;
				ring_pay[ring_tail] = m;
			end
			return st;
		end
		off = (ring_tail + RING - ip) % RING;
		st = ring_grow(now);
		if (st == ST_REJECT)
			return st;
		ip = (ring_tail + 2 * RING - off - 1) % RING;
		rd_span = (ring_tail + RING - ring_rd) % RING;
		if (off >= rd_span) begin
			ring_rd = nxt(ring_rd);
			if (st == ST_OK)
				st = ST_BEFORE;
		end
		to = ring_tail;
		for (n = 0; n < RING && to != ip; n++) begin
			ring_time[to] = ring_time[prv(to)];
			ring_pay[to] = ring_pay[prv(to)];
			to = prv(to);
		end
		ring_time[ip] = t;
		ring_pay[ip] = m;
		return st;
	endfunction

	function automatic logic [2:0] ring_append(logic [31:0] t, logic [31:0] m, logic [31:0] now);
		logic [2:0] st;
		st = ST_OK;
		if (ring_head != ring_tail && t < ring_time[ring_tail])
			return ST_ORDER;
		if (ring_head == ring_tail || t > ring_time[ring_tail]) begin
			st = ring_grow(now);
			if (st == ST_REJECT)
				return st;
		end
		ring_time[ring_tail] = t;
		ring_pay[ring_tail] = m;
		return st;
	endfunction

	function automatic logic [2:0] ring_put(logic [31:0] m, logic [31:0] now);
		logic [2:0] st;
		st = ST_OK;
		if (ring_head == ring_tail) begin
			st = ring_grow(now);
			if (st == ST_REJECT)
				return st;
			ring_time[ring_tail] = now;
			ring_pay[ring_tail] = m;
			ring_rd = ring_tail;
			return st;
		end
		if (ring_rd == ring_head || now > ring_time[ring_rd]) begin
			if (ring_rd == ring_tail) begin
				st = ring_grow(now);
				if (st == ST_REJECT)
					return st;
			end
			ring_rd = nxt(ring_rd);
		end else if (now < ring_time[ring_rd]) begin
			return ST_ORDER;
		end
		ring_time[ring_rd] = now;
		ring_pay[ring_rd] = m;
		return st;
	endfunction

	function automatic toer_res_t mk(logic [2:0] st, logic v, logic [31:0] t, logic [31:0] m);
		toer_res_t r;
		r.status = st;
		r.item_valid = v;
		r.out_time = t;
		r.out_magnitude = m;
		r.last_item = 1'b1;
		return r;
	endfunction

	task automatic predict_ring(logic [2:0] cmd, logic [31:0] t, logic [31:0] m,
			logic [31:0] now, logic [31:0] win, logic [5:0] cap, logic [4:0] back);
		int unsigned p, n, cnt;
		logic [31:0] lo;
		toer_res_t r;
		bit hit;
		hit = 1'b0;
		case (cmd)
			CMD_INSERT: pending_results.push_back(mk(ring_insert(t, m, now), 1'b0, 32'd0,
				32'd0));
			CMD_APPEND: pending_results.push_back(mk(ring_append(t, m, now), 1'b0, 32'd0,
				32'd0));
			CMD_PUT: pending_results.push_back(mk(ring_put(m, now), 1'b0, 32'd0, 32'd0));
			CMD_FIND, CMD_PREV: begin
				p = ring_rd;
				for (n = 0; n < RING && p != ring_head && !hit; n++) begin
					if (cmd == CMD_FIND ? ring_time[p] == t : back == 0) begin
						pending_results.push_back(mk(ST_OK, 1'b1, ring_time[p], ring_pay[p]));
						hit = 1'b1;
					end else begin
						if (cmd == CMD_PREV)
							back--;
						p = prv(p);
					end
				end
				if (!hit)
					pending_results.push_back(mk(ST_NFOUND, 1'b0, 32'd0, 32'd0));
			end
			CMD_LIST: begin
				lo = (win > t) ? 32'd0 : t - win;
				cnt = 0;
				if (ring_head != ring_tail && ring_rd != ring_head) begin
					p = ring_rd;
					for (n = 0; n < RING; n++) begin
						if (ring_time[p] < lo || cnt + 1 >= cap || cnt >= MAX_RES)
							break;
						if (ring_time[p] <= t) begin
							r = mk(ST_OK, 1'b1, ring_time[p], ring_pay[p]);
							r.last_item = 1'b0;
							pending_results.push_back(r);
							cnt++;
						end
						p = prv(p);
						if (p == ring_head)
							break;
					end
				end
				if (cnt == 0)
					pending_results.push_back(mk(ST_OK, 1'b0, 32'd0, 32'd0));
				else
					pending_results[$].last_item = 1'b1;
			end
			CMD_REWIND: begin
				ring_rd = ring_head;
				pending_results.push_back(mk(ST_OK, 1'b0, 32'd0, 32'd0));
			end
			default: begin
				ring_head = 0;
				ring_tail = 0;
				ring_rd = 0;
				pending_results.push_back(mk(ST_OK, 1'b0, 32'd0, 32'd0));
			end
		endcase
	endtask

	// send one command beat, with burst/gap idling on the sender side
	task automatic send_event(logic [2:0] cmd, logic [31:0] t, logic [31:0] m,
			logic [31:0] now, logic [31:0] win = 32'd0, logic [5:0] cap = 6'd32,
			logic [4:0] back = 5'd0);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) * $urandom_range(0, 1);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		s_tdata <= {2'd0, back, cap, win, now, m, t, cmd};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		predict_ring(cmd, t, m, now, win, cap, back);
		items_sent++;
	endtask

	task automatic drain_results();
		int guard;
		guard = 0;
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		cfg_idx <= idx;
		cfg_data <= val;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_POLICY)
			policy_reject = val[0];
		else
			keep_ticks = val;
		@(posedge clk);
	endtask

	// results side: stall pattern and checking
	always @(posedge clk) begin
		toer_res_t exp_r;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				beats_checked++;
				if (pending_results.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					exp_r = pending_results.pop_front();
					if (m_tdata[O_ST_LO +: 3] !== exp_r.status) begin
						$error("status exp %0d got %0d", exp_r.status, m_tdata[O_ST_LO +: 3]);
						errors++;
					end
					if (m_tuser !== exp_r.item_valid) begin
						$error("item_valid exp %0d got %0d", exp_r.item_valid, m_tuser);
						errors++;
					end
					if (m_tdata[O_TIME_LO +: 32] !== exp_r.out_time) begin
						$error("out_time exp %0h got %0h", exp_r.out_time,
							m_tdata[O_TIME_LO +: 32]);
						errors++;
					end
					if (m_tdata[O_MAG_LO +: 32] !== exp_r.out_magnitude) begin
						$error("out_magnitude exp %0h got %0h", exp_r.out_magnitude,
							m_tdata[O_MAG_LO +: 32]);
						errors++;
					end
					if (m_tlast !== exp_r.last_item) begin
						$error("last_item exp %0d got %0d", exp_r.last_item, m_tlast);
						errors++;
					end
				end
			end
			if ($urandom_range(0, 99) < 2)
				stall_on <= ~stall_on;
			m_tready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
		end
	end

	task automatic test_directed();
		send_event(CMD_FIND, 5, 0, 0);
		send_event(CMD_PREV, 0, 0, 0, 32'd0, 6'd32, 5'd31);
		send_event(CMD_LIST, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF, 6'd32);
		send_event(CMD_INSERT, 100, 32'hFFFF_FFFF, 100);
		send_event(CMD_INSERT, 50, 32'h1, 100);
		send_event(CMD_INSERT, 50, 32'h2, 100);
		send_event(CMD_APPEND, 20, 3, 100);
		send_event(CMD_APPEND, 100, 4, 100);
		send_event(CMD_APPEND, 32'hFFFF_FFFF, 5, 0);
		send_event(CMD_PUT, 0, 6, 40);
		send_event(CMD_PUT, 0, 7, 60);
		send_event(CMD_PUT, 0, 8, 60);
		send_event(CMD_INSERT, 0, 9, 60);
		send_event(CMD_FIND, 50, 0, 0);
		send_event(CMD_FIND, 77, 0, 0);
		send_event(CMD_PREV, 0, 0, 0, 32'd0, 6'd32, 5'd1);
		send_event(CMD_LIST, 60, 0, 0, 32'd0, 6'd32);
		send_event(CMD_LIST, 0, 0, 0, 32'd10, 6'd0);
		send_event(CMD_LIST, 100, 0, 0, 32'd60, 6'd2);
		send_event(CMD_REWIND, 0, 0, 0);
		send_event(CMD_LIST, 100, 0, 0, 32'd200, 6'd32);
		send_event(CMD_CLEAR, 0, 0, 0);
		drain_results();
	endtask

	// fill past capacity under a given policy
	task automatic test_full(logic reject, logic [31:0] keep);
		write_reg(CFG_POLICY, {31'd0, reject});
		write_reg(CFG_KEEP, keep);
		for (int i = 0; i < 36; i++)
			send_event(i % 3 == 0 ? CMD_PUT : CMD_APPEND, i * 10, $urandom, i * 10,
				32'd0, 6'd32, 5'd0);
		send_event(CMD_INSERT, 5, 1, 400);
		send_event(CMD_APPEND, 350, 2, 400);
		send_event(CMD_INSERT, 200, 3, 400);
		send_event(CMD_LIST, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF, 6'd32);
		send_event(CMD_CLEAR, 0, 0, 0);
		drain_results();
	endtask

	task automatic test_random(int count);
		logic [2:0] cmd;
		logic [31:0] t, nowv;
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 30) cmd = CMD_INSERT;
			else if (r < 45) cmd = CMD_APPEND;
			else if (r < 58) cmd = CMD_PUT;
			else if (r < 70) cmd = CMD_FIND;
			else if (r < 80) cmd = CMD_PREV;
			else if (r < 92) cmd = CMD_LIST;
			else if (r < 97) cmd = CMD_REWIND;
			else cmd = CMD_CLEAR;
			// mostly small clustered times so inserts, finds and windows interact
			t = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 400);
			nowv = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 450);
			send_event(cmd, t, $urandom, nowv,
				($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 300),
				6'($urandom_range(0, 32)), 5'($urandom_range(0, 31)));
		end
		drain_results();
	endtask

	initial begin
		ring_head = 0;
		ring_tail = 0;
		ring_rd = 0;
		policy_reject = 1'b0;
		keep_ticks = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full(1'b0, 32'd0);
		test_full(1'b0, 32'hFFFF_FFFF);
		test_full(1'b1, 32'd100);
		write_reg(CFG_POLICY, 32'd0);
		write_reg(CFG_KEEP, 32'd50);
		test_random(110);
		write_reg(CFG_POLICY, 32'd1);
		write_reg(CFG_KEEP, 32'd0);
		test_random(110);
		$display("Sent %0d command beats over all eight commands, both full policies",
			items_sent);
		$display("and keep ages from zero to maximum; checked %0d result beats.", beats_checked);
		if (errors == 0 && pending_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end
endmodule
